// ===== rtl/chca_pkg.sv =====
// Package for the canonical Huffman code assignment block.
// Item and result payload types, controller commands, state encoding.
// No dependencies.
package chca_pkg;

  localparam int LenW       = 4;   // code length field width
  localparam int HistW      = 9;   // histogram count width (wraps)
  localparam int NextW      = 16;  // next-code width (wraps)
  localparam int HuffW      = 15;  // emitted code width
  localparam int TblDepth   = 16;  // one entry per code length
  localparam int MaxCodeLen = 15;  // last length visited by the prefix walk

  localparam logic CmdCount  = 1'b0;
  localparam logic CmdAssign = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [LenW-1:0] code_length;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [HuffW-1:0] huff_code;
    logic [LenW-1:0]  out_length;
    logic             has_code;
  } out_item_t;

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic            clear_set;   // drop both tables before this count
    logic            count_en;    // bump histogram at the item length
    logic            assign_en;   // hand out a code, register the result
    logic            walk_en;     // one prefix walk step
    logic            walk_first;  // first walk step, running code starts at zero
    logic [LenW-1:0] walk_idx;    // length being written by the walk
  } ctrl_cmd_t;

endpackage

// ===== rtl/chca_ctrl.sv =====
// Controller for the canonical Huffman code assignment block.
// Sequences count / assign items and the prefix walk. Depends on chca_pkg.
module chca_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  chca_pkg::in_item_t  item_i,
  output logic                busy_o,
  output chca_pkg::ctrl_cmd_t cmd_o
);
  import chca_pkg::*;

  localparam logic [LenW-1:0] WalkLast = LenW'(MaxCodeLen);

  state_e          state_q, state_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic            phase_q, phase_d;   // 1 once an assign item was seen
  logic            accept;

  assign busy_o = (state_q == StWalk);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.walk_idx = idx_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (item_i.cmd == CmdCount) begin
            cmd_o.clear_set = phase_q;
            cmd_o.count_en  = 1'b1;
            phase_d         = 1'b0;
            if (item_i.last) begin
              state_d = StWalk;
              idx_d   = LenW'(1);
            end
          end else begin
            cmd_o.assign_en = 1'b1;
            phase_d         = 1'b1;
          end
        end
      end
      StWalk: begin
        cmd_o.walk_en    = 1'b1;
        cmd_o.walk_first = (idx_q == LenW'(1));
        if (idx_q == WalkLast) begin
          state_d = StIdle;
        end else begin
          idx_d = idx_q + LenW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== rtl/chca_dpath.sv =====
// Datapath for the canonical Huffman code assignment block.
// Length histogram, next-code table, walk accumulator, result register.
// Depends on chca_pkg.
module chca_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chca_pkg::ctrl_cmd_t cmd_i,
  input  chca_pkg::in_item_t  item_i,
  output chca_pkg::out_item_t result_o,
  output logic                done_o
);
  import chca_pkg::*;

  logic [HistW-1:0] hist_q [TblDepth];
  logic [NextW-1:0] next_q [TblDepth];
  logic [NextW-1:0] code_q, code_d;

  logic [LenW-1:0]  hist_addr;
  logic [HistW-1:0] hist_rd;
  logic [NextW-1:0] next_rd;
  logic [NextW-1:0] len_mask;
  out_item_t        res_d, res_q;
  logic             done_q;

  // single histogram read port: walk looks one length back, count uses the item
  assign hist_addr = cmd_i.walk_en ? (cmd_i.walk_idx - LenW'(1)) : item_i.code_length;
  assign hist_rd   = hist_q[hist_addr];
  assign next_rd   = next_q[item_i.code_length];
  assign len_mask  = (NextW'(1) << item_i.code_length) - NextW'(1);

  // code[b] = (code[b-1] + count[b-1]) << 1, count of length zero ignored
  always_comb begin
    if (cmd_i.walk_first) begin
      code_d = '0;
    end else begin
      code_d = (code_q + NextW'(hist_rd)) << 1;
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.out_length = item_i.code_length;
    if (item_i.code_length != '0) begin
      res_d.has_code  = 1'b1;
      res_d.huff_code = HuffW'(next_rd & len_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TblDepth; i++) begin
        hist_q[i] <= '0;
        next_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear_set) begin
        for (int i = 0; i < TblDepth; i++) begin
          hist_q[i] <= '0;
          next_q[i] <= '0;
        end
      end
      if (cmd_i.count_en) begin
        hist_q[item_i.code_length] <= cmd_i.clear_set ? HistW'(1)
                                                      : hist_rd + HistW'(1);
      end
      if (cmd_i.walk_en) begin
        next_q[cmd_i.walk_idx] <= code_d;
      end
      if (cmd_i.assign_en && (item_i.code_length != '0)) begin
        next_q[item_i.code_length] <= next_rd + NextW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_en) begin
      code_q <= code_d;
    end
    if (cmd_i.assign_en) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.assign_en;
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

// ===== rtl/canonical_huffman_code_assign.sv =====
// Canonical Huffman code assignment, DEFLATE style. Top level.
// An assign item's result is registered: it is on result_o with done_o in the cycle after its transfer.
// Throughput: one count or assign item per cycle while idle; a count item marked last holds busy
//   while the prefix walk steps once per code length over the histogram.
// Reset (rst_ni, async): tables zero, count phase, idle. The receiver cannot stall results.
module canonical_huffman_code_assign (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  chca_pkg::in_item_t  item_i,
  output chca_pkg::out_item_t result_o,
  output logic                done_o
);
  import chca_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  // Controller: phase tracking, new-set detection, walk sequencing.
  chca_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .item_i (item_i),
    .busy_o (busy),
    .cmd_o  (ctrl_cmd)
  );

  // Datapath: both tables, running walk code, result register.
  chca_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (ctrl_cmd),
    .item_i  (item_i),
    .result_o(result_o),
    .done_o  (done_o)
  );

  // Every result strobe follows an assign transfer.
  a_done_after_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && (item_i.cmd == CmdAssign)))
    else $error("result strobe without an assign transfer");

  // The walk only starts after a last count transfer.
  a_walk_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (item_i.cmd == CmdCount) && item_i.last))
    else $error("walk started without a last count transfer");

  // Length zero never carries a code.
  a_zero_len_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.has_code) |-> (result_o.out_length != '0))
    else $error("code issued for length zero");

  // No result can appear while the walk runs.
  a_no_result_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !done_o)
    else $error("result during prefix walk");

endmodule
